// ===== rtl/core/mfr_pkg.sv =====
// shared types and constants of the mbap frame reassembler
// no dependencies; used by every module in rtl/core
package mfr_pkg;

    localparam int unsigned HDR_LEN = 6;
    localparam int unsigned MIN_LEN = 2;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;
    localparam int unsigned BEAT_W  = 3;

    typedef logic [7:0] byte_t;
    typedef logic [CNT_W-1:0] count_t;

    // one queued request: a header replay burst or a single frame byte
    typedef struct packed {
        logic                      is_header;
        logic [HDR_LEN-1:0][7:0]   bytes;
        logic                      last;
    } req_t;

endpackage

// ===== rtl/core/mfr_front.sv =====
// front end: accepts stream bytes, tracks chunks, parses and checks the header
// depends on mfr_pkg; pushes requests into mfr_queue
module mfr_front #(
    parameter int unsigned MAX_ADU = 260,
    parameter int unsigned MAX_PDU = 253
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  mfr_pkg::byte_t data_byte,
    input  logic          segment_end,
    output logic          push,
    output mfr_pkg::req_t push_req
);
    import mfr_pkg::*;

    localparam logic [16:0] LEN_MIN     = 17'(MIN_LEN);
    localparam logic [16:0] LEN_MAX_PDU = 17'(MAX_PDU + 1);
    localparam logic [16:0] LEN_MAX_ADU = 17'(MAX_ADU - HDR_LEN);
    localparam count_t      ADU_LIMIT   = CNT_W'(MAX_ADU);
    localparam count_t      HDR_CNT     = CNT_W'(HDR_LEN);

    byte_t  hdr_reg [HDR_LEN];
    byte_t  hdr_next [HDR_LEN];
    count_t frame_count_reg, frame_count_next;
    count_t frame_total_reg, frame_total_next;
    logic   accepted_reg, accepted_next;
    logic   discarding_reg, discarding_next;
    count_t chunk_fill_reg, chunk_fill_next;
    logic   chunk_open_reg, chunk_open_next;

    always_comb begin
        count_t      fill_base;
        count_t      cnt_inc;
        logic        chunk_end;
        logic [16:0] len;
        hdr_next         = hdr_reg;
        frame_count_next = frame_count_reg;
        frame_total_next = frame_total_reg;
        accepted_next    = accepted_reg;
        discarding_next  = discarding_reg;
        chunk_fill_next  = chunk_fill_reg;
        chunk_open_next  = chunk_open_reg;
        push             = 1'b0;
        push_req.is_header = 1'b0;
        push_req.last      = 1'b0;
        for (int i = 0; i < HDR_LEN; i++) begin
            push_req.bytes[i] = hdr_reg[i];
        end
        push_req.bytes[0] = data_byte;
        fill_base = chunk_open_reg ? chunk_fill_reg : frame_count_reg;
        cnt_inc   = frame_count_reg + 1'b1;
        len       = {1'b0, hdr_reg[4], data_byte};
        chunk_end = 1'b0;
        if (accept) begin
            chunk_open_next = 1'b1;
            chunk_fill_next = fill_base + 1'b1;
            chunk_end = segment_end || (chunk_fill_next >= ADU_LIMIT);
            if (discarding_reg) begin
                // drop
            end else if (!accepted_reg) begin
                if (frame_count_reg < HDR_CNT) begin
                    hdr_next[frame_count_reg[BEAT_W-1:0]] = data_byte;
                end
                frame_count_next = cnt_inc;
                if (cnt_inc >= HDR_CNT) begin
                    if (len < LEN_MIN || len > LEN_MAX_PDU || len > LEN_MAX_ADU) begin
                        discarding_next  = 1'b1;
                        frame_count_next = '0;
                    end else begin
                        accepted_next      = 1'b1;
                        frame_total_next   = CNT_W'(len + 17'(HDR_LEN));
                        push               = 1'b1;
                        push_req.is_header = 1'b1;
                        for (int i = 0; i < HDR_LEN - 1; i++) begin
                            push_req.bytes[i] = hdr_reg[i];
                        end
                        push_req.bytes[HDR_LEN-1] = data_byte;
                    end
                end
            end else begin
                frame_count_next = cnt_inc;
                push             = 1'b1;
                push_req.last    = cnt_inc >= frame_total_reg;
                if (push_req.last) begin
                    accepted_next    = 1'b0;
                    frame_count_next = '0;
                end
            end
            if (chunk_end) begin
                chunk_open_next = 1'b0;
                if (discarding_next) begin
                    discarding_next  = 1'b0;
                    frame_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= '0;
            frame_total_reg <= '0;
            accepted_reg    <= 1'b0;
            discarding_reg  <= 1'b0;
            chunk_fill_reg  <= '0;
            chunk_open_reg  <= 1'b0;
        end else begin
            frame_count_reg <= frame_count_next;
            frame_total_reg <= frame_total_next;
            accepted_reg    <= accepted_next;
            discarding_reg  <= discarding_next;
            chunk_fill_reg  <= chunk_fill_next;
            chunk_open_reg  <= chunk_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg <= hdr_next;
    end

endmodule

// ===== rtl/core/mfr_queue.sv =====
// short request queue between front end and back end
// depends on mfr_pkg; flop storage, one push and one pop per cycle
module mfr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mfr_pkg::req_t push_req,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output mfr_pkg::req_t head_req
);
    import mfr_pkg::*;

    req_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == Q_CNT_W'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_req   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== rtl/core/mfr_back.sv =====
// back end: plays queued requests out as frame bytes through an output register
// depends on mfr_pkg; pops mfr_queue
module mfr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  mfr_pkg::req_t head_req,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output mfr_pkg::byte_t m_frame_byte,
    output logic          m_frame_start,
    output logic          m_frame_end
);
    import mfr_pkg::*;

    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(HDR_LEN - 1);

    logic              valid_reg, valid_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;
    byte_t             byte_reg, byte_next;
    logic              start_reg, start_next;
    logic              end_reg, end_next;
    logic              load;

    always_comb begin
        load       = head_valid && (!valid_reg || m_ready);
        valid_next = valid_reg;
        beat_next  = beat_reg;
        byte_next  = byte_reg;
        start_next = start_reg;
        end_next   = end_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head_req.is_header) begin
                byte_next  = head_req.bytes[beat_reg];
                start_next = beat_reg == '0;
                end_next   = 1'b0;
                if (beat_reg == LAST_BEAT) begin
                    pop       = 1'b1;
                    beat_next = '0;
                end else begin
                    beat_next = beat_reg + 1'b1;
                end
            end else begin
                byte_next  = head_req.bytes[0];
                start_next = 1'b0;
                end_next   = head_req.last;
                pop        = 1'b1;
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        start_reg <= start_next;
        end_reg   <= end_next;
    end

    assign m_valid       = valid_reg;
    assign m_frame_byte  = byte_reg;
    assign m_frame_start = start_reg;
    assign m_frame_end   = end_reg;

endmodule

// ===== rtl/core/mbap_frame_reassembler_core.sv =====
// top level of the mbap frame reassembler: front end, request queue, back end
// depends on mfr_pkg, mfr_front, mfr_queue, mfr_back
//
// channel  direction  ports
// s_       in         s_valid s_ready s_data_byte s_segment_end
// m_       out        m_valid m_ready m_frame_byte m_frame_start m_frame_end
//
// one stream byte is taken per cycle while the four-entry request queue has room
// a good header leaves the back end as six frame bytes, one per output transfer
// a queued request reaches the m_ outputs through the back end's output register
// aresetn is synchronous, active low; clears counters, flags, queue and output valid
// m_ready low stalls the back end only; the front end stalls when the queue is full
module mbap_frame_reassembler_core #(
    parameter int unsigned MAX_ADU = 260,
    parameter int unsigned MAX_PDU = 253
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mfr_pkg::byte_t s_data_byte,
    input  logic           s_segment_end,
    output logic           m_valid,
    input  logic           m_ready,
    output mfr_pkg::byte_t m_frame_byte,
    output logic           m_frame_start,
    output logic           m_frame_end
);
    import mfr_pkg::*;

    logic full;
    logic accept;
    logic push;
    logic pop;
    logic head_valid;
    req_t push_req;
    req_t head_req;

    assign s_ready = !full;
    assign accept  = s_valid && !full;

    mfr_front #(
        .MAX_ADU(MAX_ADU),
        .MAX_PDU(MAX_PDU)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_data_byte),
        .segment_end (s_segment_end),
        .push        (push),
        .push_req    (push_req)
    );

    mfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_req   (push_req),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    mfr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_req      (head_req),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_byte  (m_frame_byte),
        .m_frame_start (m_frame_start),
        .m_frame_end   (m_frame_end)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for mbap_frame_reassembler_core: mbap framing of a byte stream
// depends on mfr_pkg and the rtl under rtl/core; a scoreboard class predicts and checks
// every frame byte while random gaps and stalls hit both valid/ready channels
`timescale 1ns / 1ps

module testbench;
    import mfr_pkg::*;

    localparam int unsigned MAX_ADU = 260;
    localparam int unsigned MAX_PDU = 253;

    typedef struct {
        byte_t data;
        logic  start;
        logic  last;
    } frame_beat_t;

    class mbap_scoreboard;
        byte_t       hdr [HDR_LEN];
        count_t      frame_count;
        count_t      frame_total;
        logic        header_ok;
        logic        dropping;
        count_t      chunk_fill;
        logic        chunk_open;
        frame_beat_t frame_bytes_due[$];
        int          errors;

        function new();
            frame_count = '0;
            frame_total = '0;
            header_ok   = 1'b0;
            dropping    = 1'b0;
            chunk_fill  = '0;
            chunk_open  = 1'b0;
            errors      = 0;
        endfunction

        function void push_beat(byte_t d, logic s, logic e);
            frame_beat_t beat;
            beat.data  = d;
            beat.start = s;
            beat.last  = e;
            frame_bytes_due.push_back(beat);
        endfunction

        // one accepted byte from the stream side
        function void note_stream_byte(byte_t d, logic seg_end);
            logic        chunk_end;
            logic [15:0] len;
            logic        last;
            if (!chunk_open) begin
                chunk_open = 1'b1;
                chunk_fill = frame_count;
            end
            chunk_fill = chunk_fill + 1'b1;
            chunk_end  = seg_end || (chunk_fill >= MAX_ADU);
            if (!dropping) begin
                if (!header_ok) begin
                    if (frame_count < HDR_LEN) begin
                        hdr[frame_count] = d;
                    end
                    frame_count = frame_count + 1'b1;
                    if (frame_count >= HDR_LEN) begin
                        len = {hdr[4], hdr[5]};
                        if (len < MIN_LEN || len > MAX_PDU + 1 || HDR_LEN + len > MAX_ADU) begin
                            dropping    = 1'b1;
                            frame_count = '0;
                        end else begin
                            header_ok   = 1'b1;
                            frame_total = count_t'(HDR_LEN + len);
                            for (int i = 0; i < HDR_LEN; i++) begin
                                push_beat(hdr[i], i == 0, 1'b0);
                            end
                        end
                    end
                end else begin
                    frame_count = frame_count + 1'b1;
                    last = frame_count >= frame_total;
                    push_beat(d, 1'b0, last);
                    if (last) begin
                        header_ok   = 1'b0;
                        frame_count = '0;
                    end
                end
            end
            if (chunk_end) begin
                chunk_open = 1'b0;
                if (dropping) begin
                    dropping    = 1'b0;
                    frame_count = '0;
                end
            end
        endfunction

        function void check_frame_byte(byte_t d, logic s, logic e);
            frame_beat_t want;
            if (frame_bytes_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %h start %b end %b",
                         $time, d, s, e);
                errors++;
                return;
            end
            want = frame_bytes_due.pop_front();
            if (want.data !== d) begin
                $display("%0t: frame_byte expected %h actual %h", $time, want.data, d);
                errors++;
            end
            if (want.start !== s) begin
                $display("%0t: frame_start expected %b actual %b", $time, want.start, s);
                errors++;
            end
            if (want.last !== e) begin
                $display("%0t: frame_end expected %b actual %b", $time, want.last, e);
                errors++;
            end
        endfunction

        function int pending();
            return frame_bytes_due.size();
        endfunction

        function bit aligned();
            return frame_count == 0 && !header_ok && !dropping;
        endfunction

        function bit is_dropping();
            return dropping;
        endfunction
    endclass

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    byte_t  s_data_byte;
    logic   s_segment_end;
    logic   m_valid;
    logic   m_ready;
    byte_t  m_frame_byte;
    logic   m_frame_start;
    logic   m_frame_end;

    mbap_scoreboard sb;
    int             bytes_sent;
    bit             gaps_on;
    bit             no_idle;
    bit             hold_req;

    mbap_frame_reassembler_core #(
        .MAX_ADU(MAX_ADU),
        .MAX_PDU(MAX_PDU)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_segment_end(s_segment_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_start(m_frame_start),
        .m_frame_end  (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_frame_byte(m_frame_byte, m_frame_start, m_frame_end);
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        m_ready <= 1'b0;
        repeat (3) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (80) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    task automatic send_byte(input byte_t d, input logic se);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= d;
        s_segment_end <= se;
        do @(posedge aclk); while (!s_ready);
        sb.note_stream_byte(d, se);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [15:0] len, input bit random_se);
        byte_t d;
        for (int i = 0; i < HDR_LEN; i++) begin
            d = (i == 4) ? len[15:8] : (i == 5) ? len[7:0] : byte_t'($urandom);
            send_byte(d, random_se && $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic send_body(input int n, input bit random_se, input bit se_last);
        for (int i = 0; i < n; i++) begin
            send_byte(byte_t'($urandom),
                      (se_last && i == n - 1) || (random_se && $urandom_range(0, 7) == 0));
        end
    endtask

    // feed random bytes until the stream is back on a frame boundary
    task automatic resync();
        while (!sb.aligned()) begin
            send_byte(byte_t'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic random_frames(input int n);
        int          first;
        logic [15:0] len;
        first = bytes_sent;
        while (bytes_sent - first < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    len = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(2, 60)
                                                          : $urandom_range(2, 12));
                    send_header(len, 1'b1);
                    send_body(len, 1'b1, $urandom_range(0, 1));
                end
                6, 7: begin
                    case ($urandom_range(0, 3))
                        0:       len = 16'd0;
                        1:       len = 16'd1;
                        2:       len = 16'(MAX_PDU + 2);
                        default: len = 16'($urandom_range(MAX_PDU + 2, 16'hffff));
                    endcase
                    send_header(len, 1'b1);
                    resync();
                end
                default: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_byte(byte_t'($urandom), $urandom_range(0, 3) == 0);
                    end
                    resync();
                end
            endcase
        end
    endtask

    initial begin
        sb            = new();
        bytes_sent    = 0;
        gaps_on       = 1'b1;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        s_valid       <= 1'b0;
        s_data_byte   <= '0;
        s_segment_end <= 1'b0;
        aresetn       <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn       <= 1'b1;
        @(posedge aclk);

        // shortest good frame with all-zero and all-one bytes
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        // zero length, dropped until the segment ends
        send_header(16'h0000, 1'b0);
        send_byte(8'h5a, 1'b1);
        // length of one, segment ends on the last header byte
        for (int i = 0; i < HDR_LEN - 2; i++) begin
            send_byte(byte_t'($urandom), 1'b0);
        end
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        // largest length
        send_header(16'hffff, 1'b0);
        send_byte(8'ha5, 1'b1);

        random_frames(45);

        // header split over two segments, then dropped until the segment ends
        send_byte(byte_t'($urandom), 1'b0);
        send_byte(byte_t'($urandom), 1'b0);
        send_byte(byte_t'($urandom), 1'b1);
        send_byte(byte_t'($urandom), 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        while (sb.is_dropping()) begin
            send_byte(byte_t'($urandom), $urandom_range(0, 3) == 0);
        end
        send_header(16'd4, 1'b0);
        send_body(4, 1'b0, 1'b0);

        random_frames(30);
        wait_drained();

        // long frame sent back to back while the result side holds off
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_header(16'd36, 1'b0);
        send_body(36, 1'b0, 1'b0);
        gaps_on  = 1'b1;

        random_frames(25);
        gaps_on = 1'b0;
        no_idle = 1'b1;
        random_frames(12);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
